// ----- rtl/adcma_pkg.sv -----
// ----------------------------------------------------------------------------
// adcma_pkg: shared constants for the ADC moving average block
// Sizes of the sample ring, the running sum and the window register, and
// the window length in force after reset.
// ----------------------------------------------------------------------------
package adcma_pkg;

  // Deepest window the ring can hold, and the width of one ADC sample.
  localparam int WINDOW_MAX  = 64;
  localparam int SAMPLE_BITS = 12;

  // Width of the window length register as written on the configuration port.
  localparam int WIN_REG_W   = 7;
  localparam int WINDOW_RESET = 16;

  // Ring index, sample count and sum widths follow from the two sizes above.
  localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W = SAMPLE_BITS + IDX_W;
  localparam int CMP_W = (WIN_REG_W > CNT_W) ? WIN_REG_W : CNT_W;

  // Divider step counter covers one step per bit of the sum.
  localparam int DIV_CNT_W = $clog2(SUM_W);

  // Effective window after reset, with the same clamping as a register write.
  localparam int EFF_RESET = (WINDOW_RESET < 1) ? 1 :
                             ((WINDOW_RESET > WINDOW_MAX) ? WINDOW_MAX : WINDOW_RESET);

endpackage

// ----- rtl/adc_moving_average.sv -----
// ----------------------------------------------------------------------------
// adc_moving_average: moving average of raw ADC samples
// Each input transaction carries one sample; each result transaction carries
// the mean, rounded down, of the most recent samples and a window-full flag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_ready / sample): one ADC sample per
//   transaction. Output channel (out_valid / out_ready / average /
//   window_full): exactly one result per accepted sample, in order.
//   Configuration channel (cfg_valid / cfg_ready / window_length): writes the
//   window length (0 acts as 1, values above 64 act as 64) and clears the
//   sample history. A pending configuration write takes precedence over a
//   sample offered in the same cycle.
//   Processing: an accepted sample first updates the ring and running sum,
//   then the restoring divider retires one quotient bit per cycle over the
//   18-bit sum, and then the output register is loaded. The block takes a
//   new sample in the idle cycle after the result enters the output
//   register, so it never takes a sample before the last one is through.
//   If the receiver stalls, the result waits in the output register while the
//   next sample is processed; that one then waits until the register frees.
//   Reset clears the history and sets the window length to 16.
// ----------------------------------------------------------------------------
module adc_moving_average (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [adcma_pkg::WIN_REG_W-1:0]     window_length,
  // Sample input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [adcma_pkg::SAMPLE_BITS-1:0]   sample,
  // Result output channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [adcma_pkg::SAMPLE_BITS-1:0]   average,
  output logic                                window_full
);
  import adcma_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } state_t;

  state_t                 state;
  logic [CNT_W-1:0]       eff_window;
  logic [IDX_W-1:0]       write_index;
  logic [CNT_W-1:0]       fill_count;
  logic [SUM_W-1:0]       running_sum;
  logic [SAMPLE_BITS-1:0] sample_hold;
  logic [SAMPLE_BITS-1:0] ring_rd;
  logic [SAMPLE_BITS-1:0] sample_ring [WINDOW_MAX];

  // Divider registers: partial remainder, dividend shifting into quotient.
  logic [CNT_W-1:0]       rem;
  logic [SUM_W-1:0]       quo;
  logic [DIV_CNT_W-1:0]   div_cnt;

  logic                   cfg_fire;
  logic                   in_fire;
  logic                   out_free;
  logic [CMP_W-1:0]       win_cmp;
  logic [CNT_W-1:0]       eff_next;
  logic                   ring_full;
  logic [SUM_W-1:0]       sum_next;
  logic [CNT_W-1:0]       fill_next;
  logic [CNT_W-1:0]       inc_index;
  logic [IDX_W-1:0]       write_index_next;
  logic [CNT_W:0]         trial;
  logic                   trial_ge;

  // Handshakes: configuration wins over a sample offered in the same cycle.
  assign cfg_ready = (state == ST_IDLE);
  assign in_ready  = (state == ST_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Clamp the written window length into 1 .. WINDOW_MAX.
  always_comb begin
    win_cmp = CMP_W'(window_length);
    if (win_cmp == '0) begin
      eff_next = CNT_W'(1);
    end else if (win_cmp > CMP_W'(WINDOW_MAX)) begin
      eff_next = CNT_W'(WINDOW_MAX);
    end else begin
      eff_next = CNT_W'(win_cmp);
    end
  end

  // Ring and sum update for the sample being processed.
  always_comb begin
    ring_full = (fill_count >= eff_window);
    sum_next  = running_sum - (ring_full ? SUM_W'(ring_rd) : '0) + SUM_W'(sample_hold);
    fill_next = ring_full ? eff_window : fill_count + CNT_W'(1);
    inc_index = CNT_W'(write_index) + CNT_W'(1);
    if (inc_index >= eff_window) begin
      write_index_next = '0;
    end else begin
      write_index_next = inc_index[IDX_W-1:0];
    end
  end

  // One restoring division step: shift in the next dividend bit and try the divisor.
  always_comb begin
    trial    = {rem, quo[SUM_W-1]};
    trial_ge = (trial >= {1'b0, fill_count});
  end

  // Sample ring: read at the write index every cycle, written once per sample.
  always_ff @(posedge clk) begin
    ring_rd <= sample_ring[write_index];
    if (state == ST_UPDATE) begin
      sample_ring[write_index] <= sample_hold;
    end
  end

  // Sequencer, history state, divider and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      eff_window  <= CNT_W'(EFF_RESET);
      write_index <= '0;
      fill_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
      div_cnt     <= '0;
    end else begin
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cfg_fire) begin
            eff_window  <= eff_next;
            write_index <= '0;
            fill_count  <= '0;
            running_sum <= '0;
          end else if (in_fire) begin
            sample_hold <= sample;
            state       <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          running_sum <= sum_next;
          fill_count  <= fill_next;
          write_index <= write_index_next;
          quo         <= sum_next;
          rem         <= '0;
          div_cnt     <= DIV_CNT_W'(SUM_W - 1);
          state       <= ST_DIV;
        end
        ST_DIV: begin
          if (trial_ge) begin
            rem <= CNT_W'(trial - {1'b0, fill_count});
          end else begin
            rem <= trial[CNT_W-1:0];
          end
          quo <= {quo[SUM_W-2:0], trial_ge};
          if (div_cnt == '0) begin
            state <= ST_DONE;
          end else begin
            div_cnt <= div_cnt - DIV_CNT_W'(1);
          end
        end
        ST_DONE: begin
          if (out_free) begin
            average     <= quo[SAMPLE_BITS-1:0];
            window_full <= (fill_count == eff_window);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The sample count never exceeds the window in force.
  assert property (@(posedge clk) disable iff (rst) fill_count <= eff_window)
    else $error("fill count exceeds the effective window");

  // The write pointer always stays inside the active part of the ring.
  assert property (@(posedge clk) disable iff (rst) CNT_W'(write_index) < eff_window)
    else $error("write index outside the active window");

  // The update step only ever follows an accepted sample transaction.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> $past(in_valid && in_ready))
    else $error("ring update without an accepted sample");

  // The last divider step hands over to the output stage.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_cnt == '0) |=> (state == ST_DONE))
    else $error("divider did not finish after its last step");

  // A new result only appears when a finished quotient was waiting.
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised without a finished division");

endmodule

// ----- verif/adc_moving_average_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adc_moving_average_tb: self-checking bench for the ADC moving average block
// A queue-fed driver offers samples and a clocked monitor compares each result
// with the mean worked out by an in-bench model of the ring and running sum.
// The run steps through many window settings and four pacing styles.
// ----------------------------------------------------------------------------
module adc_moving_average_tb;

  import adcma_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASE_ITEMS = 100;
  localparam int NUM_PHASES = 16;
  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;

  typedef enum int {PACE_FULL, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] average;
    logic                   window_full;
  } mean_t;

  // Clock, reset and block ports; the ones the bench drives are known from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [WIN_REG_W-1:0]   window_length = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [SAMPLE_BITS-1:0] sample = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [SAMPLE_BITS-1:0] average;
  logic                   window_full;

  // Stimulus and expectation stores.
  logic [SAMPLE_BITS-1:0] sample_queue[$];
  mean_t                  mean_queue[$];

  // Pacing knobs, changed only between phases.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Bookkeeping.
  int mismatches = 0;
  int results_checked = 0;
  int samples_sent = 0;
  int windows_written = 0;
  int cycle_count = 0;

  // Model state: the sample ring, its write position, the number of samples
  // held, their sum, and the effective window length.
  logic [SAMPLE_BITS-1:0] hist_ring [WINDOW_MAX];
  int                     ring_pos = 0;
  int                     held_count = 0;
  logic [SUM_W-1:0]       sample_sum = '0;
  int                     span = EFF_RESET;

  // Window settings for the random phases; the last three are drawn at run time.
  logic [WIN_REG_W-1:0] phase_window [NUM_PHASES] =
    '{7'd64, 7'd127, 7'd1, 7'd2, 7'd3, 7'd65, 7'd63, 7'd0,
      7'd100, 7'd5, 7'd32, 7'd64, 7'd17, 7'd0, 7'd0, 7'd0};

  adc_moving_average uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .window_length(window_length),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample       (sample),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .average      (average),
    .window_full  (window_full)
  );

  // Free-running clock, 8 ns period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply a window register write to the model: clamp it and drop the history.
  function automatic void load_window(logic [WIN_REG_W-1:0] w);
    if (w < 1) begin
      span = 1;
    end else if (w > WINDOW_MAX) begin
      span = WINDOW_MAX;
    end else begin
      span = w;
    end
    ring_pos = 0;
    held_count = 0;
    sample_sum = '0;
  endfunction

  // Push one sample through the model and return the mean it produces.
  function automatic mean_t next_mean(logic [SAMPLE_BITS-1:0] s);
    mean_t r;
    int    pos;
    pos = ring_pos;
    if (pos >= span) begin
      pos = 0;
    end
    // Once the window is full the oldest sample leaves the sum.
    if (held_count >= span) begin
      sample_sum = sample_sum - hist_ring[pos];
      held_count = span;
    end else begin
      held_count = held_count + 1;
    end
    hist_ring[pos] = s;
    sample_sum = sample_sum + s;
    pos = pos + 1;
    if (pos >= span) begin
      pos = 0;
    end
    ring_pos = pos;
    r.average = SAMPLE_BITS'(sample_sum / held_count);
    r.window_full = (held_count == span);
    return r;
  endfunction

  // Driver: offers the next queued sample, holding it until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        sample <= sample_queue[0];
        sample_queue.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: tracks accepted writes and samples in the model, checks results.
  always @(posedge clk) begin
    mean_t got;
    mean_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        load_window(window_length);
      end
      if (in_valid && in_ready) begin
        mean_queue = {mean_queue, next_mean(sample)};
        samples_sent++;
      end
      if (out_valid && out_ready) begin
        got.average = average;
        got.window_full = window_full;
        if (mean_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: result with nothing expected: average %0d window_full %0b",
                     got.average, got.window_full);
          end
        end else begin
          want = mean_queue[0];
          mean_queue.delete(0);
          results_checked++;
          if (got.average !== want.average || got.window_full !== want.window_full) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"ERROR: result %0d: average %0d (expected %0d), ",
                        "window_full %0b (expected %0b)"},
                       results_checked, got.average, want.average,
                       got.window_full, want.window_full);
            end
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timed out after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  // Set how often the sender idles and the receiver stalls.
  task automatic set_pace(pace_t p);
    case (p)
      PACE_FULL: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      PACE_SEND_IDLE: begin
        send_idle_pct = 71;
        recv_stall_pct = 0;
      end
      PACE_RECV_STALL: begin
        send_idle_pct = 0;
        recv_stall_pct = 71;
      end
      default: begin
        send_idle_pct = 19;
        recv_stall_pct = 19;
      end
    endcase
  endtask

  // Wait until every queued sample is taken and every result has come back.
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (sample_queue.size() != 0 || in_valid || mean_queue.size() != 0);
  endtask

  // Write the window register; only called while the block is idle.
  task automatic write_window(logic [WIN_REG_W-1:0] w);
    @(posedge clk);
    cfg_valid <= 1'b1;
    window_length <= w;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    windows_written++;
    @(negedge clk);
  endtask

  // Draw a sample; heavy phases lean on full scale to reach the largest sums.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(bit heavy);
    int pick;
    pick = $urandom_range(9);
    if (heavy && pick < 8) begin
      return FULL_SCALE;
    end
    if (pick == 0) begin
      return '0;
    end
    if (pick == 1) begin
      return FULL_SCALE;
    end
    return SAMPLE_BITS'($urandom_range(FULL_SCALE));
  endfunction

  // Main sequence.
  initial begin
    logic [WIN_REG_W-1:0] w;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: reset window of 16, extremes, alternating bit patterns, and
    // enough full-scale samples to fill and wrap the ring.
    set_pace(PACE_FULL);
    sample_queue = {12'd0, 12'hFFF, 12'hFFF, 12'd1, 12'hAAA, 12'h555, 12'd2048, 12'hFFE};
    repeat (10) sample_queue = {sample_queue, FULL_SCALE};
    wait_drained();

    // Directed: a window of zero acts as a window of one.
    write_window(7'd0);
    sample_queue = {12'hFFF, 12'd0, 12'd7};
    wait_drained();

    // Directed: the smallest real window, then the saturating one.
    write_window(7'd1);
    sample_queue = {12'hFFF, 12'd1};
    wait_drained();
    write_window(7'd127);
    sample_queue = {12'hFFF, 12'h800};
    wait_drained();

    // Random phases over many window lengths and every pacing style.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      w = (ph >= NUM_PHASES - 3) ? WIN_REG_W'($urandom_range(127)) : phase_window[ph];
      set_pace(pace_t'(ph % 4));
      write_window(w);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        sample_queue = {sample_queue, draw_sample(ph == 0 || ph == 11)};
      end
      wait_drained();
    end

    // Let any stray result show up before the final verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mean_queue.size() != 0) begin
      mismatches += mean_queue.size();
      $display("ERROR: %0d expected results never arrived", mean_queue.size());
    end

    $display("Run covered %0d samples and %0d checked results over %0d window writes.",
             samples_sent, results_checked, windows_written);
    $display("Mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
